>>> design/gkrd_pkg.sv
// ----------------------------------------------------------------------------
// gkrd_pkg
// Shared types and constants of the Gaussian kernel block.
// ----------------------------------------------------------------------------
package gkrd_pkg;

  localparam logic [2:0] CFG_INV_RANGE    = 3'd0;
  localparam logic [2:0] CFG_INV_RANGE_SQ = 3'd1;
  localparam logic [2:0] CFG_TWICE_RANGE  = 3'd2;
  localparam logic [2:0] CFG_NUGGET       = 3'd3;
  localparam logic [2:0] CFG_ZERO_DIST    = 3'd4;

  localparam logic [51:0] ACC_MAX    = {52{1'b1}};
  localparam logic [62:0] X_CAP      = 63'(32) << 24;
  localparam logic [62:0] ONE_Q40    = 63'(1) << 40;
  localparam logic [62:0] BIG_CAP    = 63'(1) << 62;
  localparam logic [62:0] DK_MAX     = (63'(1) << 46) - 63'(1);
  localparam logic [62:0] D2_POS_MAX = (63'(1) << 47) - 63'(1);
  localparam logic [62:0] D2_NEG_MAX = 63'(1) << 47;

  typedef struct packed {
    logic [31:0] inv_range;
    logic [31:0] inv_range_sq;
    logic [31:0] twice_range;
    logic [15:0] nugget;
    logic        zero_dist_nugget;
  } cfg_t;

  typedef struct packed {
    logic [51:0] sq_dist;
    logic        diagonal;
    logic        matrix_done;
  } pair_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
    logic [5:0]  shift;
    logic [62:0] cap;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [62:0] value;
  } mul_rsp_t;

  typedef struct packed {
    logic [51:0]        sq_distance;
    logic [30:0]        corr;
    logic [45:0]        d_corr;
    logic signed [47:0] d2_corr;
    logic               matrix_done;
  } result_t;

endpackage

>>> design/gkrd_fifo.sv
// ----------------------------------------------------------------------------
// gkrd_fifo
// Two-entry queue of finished distances between the front and the back.
// ----------------------------------------------------------------------------
module gkrd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  gkrd_pkg::pair_t wdata,
  output logic           full,
  input  logic           pop,
  output gkrd_pkg::pair_t rdata,
  output logic           empty
);

  gkrd_pkg::pair_t mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push;
  logic       do_pop;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

>>> design/gkrd_front.sv
// ----------------------------------------------------------------------------
// gkrd_front
// Accepts items and accumulates the saturating squared distance of a pair.
// ----------------------------------------------------------------------------
module gkrd_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_action,
  input  logic signed [23:0] in_coord_a,
  input  logic signed [23:0] in_coord_b,
  input  logic [51:0]        in_distance_in,
  input  logic               in_last_coord,
  input  logic               in_diagonal,
  input  logic               in_end_of_matrix,
  output logic               q_push,
  output gkrd_pkg::pair_t    q_wdata,
  input  logic               q_full
);

  logic [51:0]        dist_accum_r;
  logic [51:0]        dist_accum_nxt;
  logic signed [24:0] diff;
  logic [23:0]        mag;
  logic [47:0]        sq;
  logic [52:0]        sum;
  logic               accept;

  assign accept = in_push && !q_full;
  assign in_full = q_full;

  always_comb begin
    diff = 25'(in_coord_a) - 25'(in_coord_b);
    mag  = diff[24] ? 24'(-diff) : diff[23:0];
    sq   = 48'(mag) * 48'(mag);
    sum  = 53'(dist_accum_r) + 53'(sq);
    if (in_action) begin
      dist_accum_nxt = in_distance_in;
    end else if (sum[52]) begin
      dist_accum_nxt = gkrd_pkg::ACC_MAX;
    end else begin
      dist_accum_nxt = sum[51:0];
    end
  end

  assign q_push              = accept && in_last_coord;
  assign q_wdata.sq_dist     = dist_accum_nxt;
  assign q_wdata.diagonal    = in_diagonal;
  assign q_wdata.matrix_done = in_end_of_matrix;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_accum_r <= '0;
    end else if (accept) begin
      dist_accum_r <= in_last_coord ? '0 : dist_accum_nxt;
    end
  end

endmodule

>>> design/gkrd_mul.sv
// ----------------------------------------------------------------------------
// gkrd_mul
// Shared 64 by 64 multiplier built from four 32 by 32 partial products, with
// a final shift and saturation.
// ----------------------------------------------------------------------------
module gkrd_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  gkrd_pkg::mul_req_t req,
  output gkrd_pkg::mul_rsp_t rsp
);

  logic [63:0]  a_r;
  logic [63:0]  b_r;
  logic [5:0]   shift_r;
  logic [62:0]  cap_r;
  logic [127:0] acc_r;
  logic [2:0]   cnt_r;
  logic         busy_r;
  logic         done_r;
  logic [62:0]  res_r;
  logic [31:0]  a_part;
  logic [31:0]  b_part;
  logic [63:0]  pp;
  logic [1:0]   pos;
  logic [127:0] pp_sh;
  logic [127:0] sh;

  always_comb begin
    a_part = cnt_r[1] ? a_r[63:32] : a_r[31:0];
    b_part = cnt_r[0] ? b_r[63:32] : b_r[31:0];
    pp     = 64'(a_part) * 64'(b_part);
    pos    = {1'b0, cnt_r[1]} + {1'b0, cnt_r[0]};
    pp_sh  = 128'(pp) << {pos, 5'b0};
    sh     = acc_r >> shift_r;
  end

  assign rsp.done  = done_r;
  assign rsp.value = res_r;

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r     <= req.a;
      b_r     <= req.b;
      shift_r <= req.shift;
      cap_r   <= req.cap;
      acc_r   <= '0;
    end else if (busy_r && !cnt_r[2]) begin
      acc_r <= acc_r + pp_sh;
    end
    if (busy_r && cnt_r[2]) begin
      if ((|sh[127:64]) || (sh[63:0] > {1'b0, cap_r})) begin
        res_r <= cap_r;
      end else begin
        res_r <= sh[62:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && cnt_r[2];
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r[2]) begin
          busy_r <= 1'b0;
        end
        cnt_r <= cnt_r + 3'd1;
      end
    end
  end

endmodule

>>> design/gkrd_back.sv
// ----------------------------------------------------------------------------
// gkrd_back
// Sequencer that turns a finished distance into the correlation and its
// derivatives, using the exp tables and the shared multiplier.
// ----------------------------------------------------------------------------
module gkrd_back #(
  parameter int EXP_TABLE_SIZE = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  gkrd_pkg::cfg_t    cfg,
  input  gkrd_pkg::pair_t   q_rdata,
  input  logic              q_empty,
  output logic              q_pop,
  output gkrd_pkg::mul_req_t mul_req,
  input  gkrd_pkg::mul_rsp_t mul_rsp,
  output gkrd_pkg::result_t out_res,
  output logic              out_valid,
  input  logic              out_pop
);

  localparam int AW = $clog2(EXP_TABLE_SIZE + 1);

  typedef logic [40:0] frac_tab_t [0:EXP_TABLE_SIZE];
  typedef logic [40:0] int_tab_t [0:31];
  typedef logic [63:0] div_tab_t [1:24];

  function automatic div_tab_t build_div();
    div_tab_t t;
    for (int i = 1; i <= 24; i++) begin
      t[i] = 64'(EXP_TABLE_SIZE) * 64'(i);
    end
    return t;
  endfunction

  localparam div_tab_t SERIES_DIV = build_div();

  function automatic logic [40:0] series_exp(input int unsigned k);
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    term = 64'(1) << 40;
    pos  = 64'(1) << 40;
    neg  = '0;
    for (int i = 1; i <= 24; i++) begin
      term = (term * 64'(k)) / SERIES_DIV[i];
      if ((i & 1) != 0) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    return (pos >= neg) ? 41'(pos - neg) : '0;
  endfunction

  function automatic frac_tab_t build_frac();
    frac_tab_t t;
    for (int k = 0; k <= EXP_TABLE_SIZE; k++) begin
      t[k] = series_exp(k);
    end
    return t;
  endfunction

  function automatic int_tab_t build_int();
    int_tab_t    t;
    logic [40:0] last;
    logic [81:0] p;
    last = series_exp(EXP_TABLE_SIZE);
    t[0] = 41'(1) << 40;
    for (int k = 1; k < 32; k++) begin
      p = (82'(t[k-1]) * 82'(last)) >> 40;
      t[k] = (p > 82'(1) << 40) ? 41'(1) << 40 : p[40:0];
    end
    return t;
  endfunction

  localparam frac_tab_t FRAC_TAB = build_frac();
  localparam int_tab_t  INT_TAB  = build_int();

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_X      = 11'b000_0000_0010,
    ST_RDA    = 11'b000_0000_0100,
    ST_RDB    = 11'b000_0000_1000,
    ST_DIFF   = 11'b000_0001_0000,
    ST_INTERP = 11'b000_0010_0000,
    ST_E      = 11'b000_0100_0000,
    ST_P      = 11'b000_1000_0000,
    ST_DK     = 11'b001_0000_0000,
    ST_M1     = 11'b010_0000_0000,
    ST_M2     = 11'b100_0000_0000
  } state_t;

  state_t      state_r;
  state_t      state_nxt;
  logic [51:0] dist_r;
  logic        eom_r;
  logic        neg_r;
  logic [51:0] mag_r;
  logic [4:0]  n_r;
  logic [AW-1:0] idx_r;
  logic [23:0] rem_r;
  logic [40:0] a_r;
  logic [40:0] e_r;
  logic [62:0] dk_r;
  logic [40:0] rom_q_r;
  logic [AW-1:0] rom_addr;
  logic        out_valid_r;
  gkrd_pkg::result_t out_r;

  logic        special;
  logic        take;
  logic [51:0] tw;
  logic [23+AW:0] fs;
  logic [AW-1:0] idx_c;
  logic [40:0] diff;
  logic [40:0] ef;
  logic [41:0] corr_sum;
  logic [62:0] m;
  logic [47:0] d2;

  assign special = q_rdata.diagonal ||
                   ((q_rdata.sq_dist == '0) && cfg.zero_dist_nugget);
  assign tw    = {4'b0, cfg.twice_range, 16'b0};
  assign fs    = (24 + AW)'(mul_rsp.value[23:0]) * (24 + AW)'(EXP_TABLE_SIZE);
  assign idx_c = (fs[23+AW:24] >= AW'(EXP_TABLE_SIZE)) ?
                 AW'(EXP_TABLE_SIZE - 1) : fs[23+AW:24];
  assign diff  = (a_r > rom_q_r) ? a_r - rom_q_r : '0;
  assign ef    = a_r - mul_rsp.value[40:0];
  assign corr_sum = 42'(e_r) + 42'd512;
  assign m     = mul_rsp.value;
  assign rom_addr = (state_r == ST_RDB) ? idx_r + AW'(1) : idx_r;

  always_comb begin
    if (neg_r) begin
      d2 = (m > gkrd_pkg::D2_NEG_MAX) ? 48'(-gkrd_pkg::D2_NEG_MAX) : 48'(-m);
    end else begin
      d2 = (m > gkrd_pkg::D2_POS_MAX) ? gkrd_pkg::D2_POS_MAX[47:0] : m[47:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    take          = 1'b0;
    mul_req       = '0;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty && !out_valid_r) begin
          take = 1'b1;
          if (!special) begin
            mul_req = '{1'b1, 64'(q_rdata.sq_dist), 64'(cfg.inv_range), 6'd24,
                        gkrd_pkg::X_CAP};
            state_nxt = ST_X;
          end
        end
      end
      ST_X: begin
        if (mul_rsp.done) begin
          if (mul_rsp.value >= gkrd_pkg::X_CAP) begin
            mul_req = '{1'b1, 64'(dist_r), 64'(0), 6'd40, gkrd_pkg::BIG_CAP};
            state_nxt = ST_P;
          end else begin
            state_nxt = ST_RDA;
          end
        end
      end
      ST_RDA: state_nxt = ST_RDB;
      ST_RDB: state_nxt = ST_DIFF;
      ST_DIFF: begin
        mul_req = '{1'b1, 64'(diff), 64'(rem_r), 6'd24, gkrd_pkg::BIG_CAP};
        state_nxt = ST_INTERP;
      end
      ST_INTERP: begin
        if (mul_rsp.done) begin
          mul_req = '{1'b1, 64'(INT_TAB[n_r]), 64'(ef), 6'd40, gkrd_pkg::ONE_Q40};
          state_nxt = ST_E;
        end
      end
      ST_E: begin
        if (mul_rsp.done) begin
          mul_req = '{1'b1, 64'(dist_r), 64'(mul_rsp.value), 6'd40,
                      gkrd_pkg::BIG_CAP};
          state_nxt = ST_P;
        end
      end
      ST_P: begin
        if (mul_rsp.done) begin
          mul_req = '{1'b1, 64'(mul_rsp.value), 64'(cfg.inv_range_sq), 6'd18,
                      gkrd_pkg::BIG_CAP};
          state_nxt = ST_DK;
        end
      end
      ST_DK: begin
        if (mul_rsp.done) begin
          mul_req = '{1'b1, 64'(mul_rsp.value), 64'(mag_r), 6'd32,
                      gkrd_pkg::BIG_CAP};
          state_nxt = ST_M1;
        end
      end
      ST_M1: begin
        if (mul_rsp.done) begin
          mul_req = '{1'b1, 64'(mul_rsp.value), 64'(cfg.inv_range_sq), 6'd16,
                      gkrd_pkg::BIG_CAP};
          state_nxt = ST_M2;
        end
      end
      ST_M2: begin
        if (mul_rsp.done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign q_pop     = take;
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  always_ff @(posedge clk) begin
    rom_q_r <= FRAC_TAB[rom_addr];
    if (take) begin
      dist_r <= q_rdata.sq_dist;
      eom_r  <= q_rdata.matrix_done;
      neg_r  <= q_rdata.sq_dist < tw;
      mag_r  <= (q_rdata.sq_dist < tw) ? tw - q_rdata.sq_dist : q_rdata.sq_dist - tw;
    end
    if ((state_r == ST_X) && mul_rsp.done) begin
      e_r   <= '0;
      n_r   <= mul_rsp.value[28:24];
      idx_r <= idx_c;
      rem_r <= fs[23:0];
    end
    if (state_r == ST_RDB) begin
      a_r <= rom_q_r;
    end
    if ((state_r == ST_E) && mul_rsp.done) begin
      e_r <= mul_rsp.value[40:0];
    end
    if ((state_r == ST_DK) && mul_rsp.done) begin
      dk_r <= mul_rsp.value;
    end
    if (take && special) begin
      out_r.sq_distance <= q_rdata.sq_dist;
      out_r.corr        <= 31'(1) << 30 | 31'({cfg.nugget, 14'b0});
      out_r.d_corr      <= '0;
      out_r.d2_corr     <= '0;
      out_r.matrix_done <= q_rdata.matrix_done;
    end else if ((state_r == ST_M2) && mul_rsp.done) begin
      out_r.sq_distance <= dist_r;
      out_r.corr        <= corr_sum[40:10];
      out_r.d_corr      <= (dk_r > gkrd_pkg::DK_MAX) ? gkrd_pkg::DK_MAX[45:0]
                                                     : dk_r[45:0];
      out_r.d2_corr     <= d2;
      out_r.matrix_done <= eom_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((take && special) || ((state_r == ST_M2) && mul_rsp.done)) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

>>> design/gaussian_kernel_with_range_derivs_core.sv
// ----------------------------------------------------------------------------
// gaussian_kernel_with_range_derivs_core
// Gaussian correlation entry with first and second range derivatives.
// ----------------------------------------------------------------------------
// Coordinate items are taken one per cycle and summed into a saturating
// squared distance; the item that closes a pair places the distance in a
// two-entry queue. A sequencer then works out the correlation and both
// derivatives on one shared multiplier that forms each wide product from four
// 32 by 32 partial products, one per cycle. A regular pair needs seven wide
// products, with the exp table reads and the interpolation set-up in the states
// RDA, RDB and DIFF between the first and the second; when the exponent
// reaches its cap the table steps are skipped. Diagonal pairs, and zero-distance
// pairs when the zero-distance nugget is enabled, skip the multiplier: the
// result is registered as the pair leaves the queue. A pair leaves the
// queue only once the previous result has been popped, and the front stalls
// only when the queue is full.
// ----------------------------------------------------------------------------
module gaussian_kernel_with_range_derivs_core #(
  parameter int EXP_TABLE_SIZE = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               push,
  output logic               full,
  input  logic               in_action,
  input  logic signed [23:0] in_coord_a,
  input  logic signed [23:0] in_coord_b,
  input  logic [51:0]        in_distance_in,
  input  logic               in_last_coord,
  input  logic               in_diagonal,
  input  logic               in_end_of_matrix,
  output logic               empty,
  input  logic               pop,
  output logic [51:0]        out_sq_distance,
  output logic [30:0]        out_corr,
  output logic [45:0]        out_d_corr,
  output logic signed [47:0] out_d2_corr,
  output logic               out_matrix_done
);

  gkrd_pkg::cfg_t     cfg_r;
  gkrd_pkg::pair_t    q_wdata;
  gkrd_pkg::pair_t    q_rdata;
  gkrd_pkg::mul_req_t mul_req;
  gkrd_pkg::mul_rsp_t mul_rsp;
  gkrd_pkg::result_t  res;
  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_empty;
  logic               out_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.inv_range        <= 32'd65536;
      cfg_r.inv_range_sq     <= 32'd65536;
      cfg_r.twice_range      <= 32'd131072;
      cfg_r.nugget           <= '0;
      cfg_r.zero_dist_nugget <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        gkrd_pkg::CFG_INV_RANGE:    cfg_r.inv_range        <= cfg_wdata;
        gkrd_pkg::CFG_INV_RANGE_SQ: cfg_r.inv_range_sq     <= cfg_wdata;
        gkrd_pkg::CFG_TWICE_RANGE:  cfg_r.twice_range      <= cfg_wdata;
        gkrd_pkg::CFG_NUGGET:       cfg_r.nugget           <= cfg_wdata[15:0];
        gkrd_pkg::CFG_ZERO_DIST:    cfg_r.zero_dist_nugget <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  gkrd_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (push),
    .in_full          (full),
    .in_action        (in_action),
    .in_coord_a       (in_coord_a),
    .in_coord_b       (in_coord_b),
    .in_distance_in   (in_distance_in),
    .in_last_coord    (in_last_coord),
    .in_diagonal      (in_diagonal),
    .in_end_of_matrix (in_end_of_matrix),
    .q_push           (q_push),
    .q_wdata          (q_wdata),
    .q_full           (q_full)
  );

  gkrd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  gkrd_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  gkrd_back #(
    .EXP_TABLE_SIZE (EXP_TABLE_SIZE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_rdata   (q_rdata),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .mul_req   (mul_req),
    .mul_rsp   (mul_rsp),
    .out_res   (res),
    .out_valid (out_valid),
    .out_pop   (pop)
  );

  assign empty           = !out_valid;
  assign out_sq_distance = res.sq_distance;
  assign out_corr        = res.corr;
  assign out_d_corr      = res.d_corr;
  assign out_d2_corr     = res.d2_corr;
  assign out_matrix_done = res.matrix_done;

`ifndef SYNTHESIS
  a_empty_after_reset: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result shown straight after reset");
  a_d2_needs_d1: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_d_corr == 46'd0) |-> out_d2_corr == 48'sd0)
    else $error("second derivative without first derivative");
  a_corr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> out_corr <= 31'h7FFF_C000)
    else $error("correlation above one plus nugget");
`endif

endmodule

>>> dv/tb_gaussian_kernel_with_range_derivs_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gaussian_kernel_with_range_derivs_core
// Self-checking bench for the Gaussian kernel block with range derivatives.
// Directed and random coordinate items go in over the push side, and an
// in-bench model of the fixed-point kernel predicts each pair result. The
// results popped out are compared field by field, under random stalls on
// both sides and over several register settings.
// ----------------------------------------------------------------------------
module tb_gaussian_kernel_with_range_derivs_core;

  localparam int TAB_SIZE = 256;
  localparam int WATCHDOG_LIMIT = 20000;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_wdata;
  logic               push;
  logic               full;
  logic               in_action;
  logic signed [23:0] in_coord_a;
  logic signed [23:0] in_coord_b;
  logic [51:0]        in_distance_in;
  logic               in_last_coord;
  logic               in_diagonal;
  logic               in_end_of_matrix;
  logic               empty;
  logic               pop;
  logic [51:0]        out_sq_distance;
  logic [30:0]        out_corr;
  logic [45:0]        out_d_corr;
  logic signed [47:0] out_d2_corr;
  logic               out_matrix_done;

  gaussian_kernel_with_range_derivs_core dut (.*);

  logic [63:0] frac_tab [0:TAB_SIZE];
  logic [63:0] int_tab [0:31];
  logic [31:0] m_inv_range;
  logic [31:0] m_inv_range_sq;
  logic [31:0] m_twice_range;
  logic [15:0] m_nugget;
  logic        m_zero_dist;
  logic [51:0] m_dist_sum;
  gkrd_pkg::result_t kernel_q[$];
  int          errors;
  bit          idle_on;
  int          stuck_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int s,
                                            logic [63:0] cap);
    logic [127:0] p;
    p = ({64'b0, a} * {64'b0, b}) >> s;
    if (p > {64'b0, cap}) return cap;
    return p[63:0];
  endfunction

  function automatic logic [63:0] series_exp(logic [63:0] k);
    logic [63:0] term, pos, neg;
    term = gkrd_pkg::ONE_Q40;
    pos = gkrd_pkg::ONE_Q40;
    neg = 0;
    for (int i = 1; i <= 24; i++) begin
      term = (term * k) / (TAB_SIZE * i);
      if (i % 2) neg += term;
      else pos += term;
    end
    return (pos >= neg) ? pos - neg : 64'd0;
  endfunction

  function automatic logic [63:0] exp_neg(logic [63:0] x);
    logic [63:0] fs, idx, rem, a, b, diff, ef;
    if (x >= gkrd_pkg::X_CAP) return 64'd0;
    fs = (x & 64'hFFFFFF) * TAB_SIZE;
    idx = fs >> 24;
    rem = fs & 64'hFFFFFF;
    if (idx >= TAB_SIZE) idx = TAB_SIZE - 1;
    a = frac_tab[idx];
    b = frac_tab[idx + 1];
    diff = (a > b) ? a - b : 64'd0;
    ef = a - ((diff * rem) >> 24);
    return mul_shift(int_tab[(x >> 24) & 31], ef, 40, gkrd_pkg::ONE_Q40);
  endfunction

  function automatic void build_exp_tables();
    for (int k = 0; k <= TAB_SIZE; k++) frac_tab[k] = series_exp(k);
    int_tab[0] = gkrd_pkg::ONE_Q40;
    for (int k = 1; k < 32; k++)
      int_tab[k] = mul_shift(int_tab[k-1], frac_tab[TAB_SIZE], 40, gkrd_pkg::ONE_Q40);
  endfunction

  function automatic void predict_kernel(logic action, logic signed [23:0] ca,
                                         logic signed [23:0] cb, logic [51:0] dist_in,
                                         logic last, logic diag, logic eom);
    logic signed [24:0] df;
    logic [63:0] u, sum, pair_dist, e, p, dk, tw, mag, m;
    logic neg;
    gkrd_pkg::result_t r;
    if (action) begin
      m_dist_sum = dist_in;
    end else begin
      df = 25'(ca) - 25'(cb);
      u = (df < 0) ? 64'(-df) : 64'(df);
      sum = 64'(m_dist_sum) + u * u;
      m_dist_sum = (sum > 64'(gkrd_pkg::ACC_MAX)) ? gkrd_pkg::ACC_MAX : sum[51:0];
    end
    if (!last) return;
    pair_dist = m_dist_sum;
    m_dist_sum = 0;
    r.sq_distance = pair_dist[51:0];
    r.matrix_done = eom;
    r.d_corr = 0;
    r.d2_corr = 0;
    if (diag || (pair_dist == 0 && m_zero_dist)) begin
      r.corr = 31'(64'(1) << 30) + (31'(m_nugget) << 14);
    end else begin
      e = exp_neg(mul_shift(pair_dist, m_inv_range, 24, gkrd_pkg::X_CAP));
      r.corr = 31'((e + 512) >> 10);
      p = mul_shift(pair_dist, e, 40, gkrd_pkg::BIG_CAP);
      dk = mul_shift(p, m_inv_range_sq, 18, gkrd_pkg::BIG_CAP);
      tw = 64'(m_twice_range) << 16;
      neg = pair_dist < tw;
      mag = neg ? tw - pair_dist : pair_dist - tw;
      m = mul_shift(dk, mag, 32, gkrd_pkg::BIG_CAP);
      m = mul_shift(m, m_inv_range_sq, 16, gkrd_pkg::BIG_CAP);
      if (neg) begin
        if (m > gkrd_pkg::D2_NEG_MAX) m = gkrd_pkg::D2_NEG_MAX;
        r.d2_corr = 48'(-m);
      end else begin
        r.d2_corr = (m > gkrd_pkg::D2_POS_MAX) ? 48'(gkrd_pkg::D2_POS_MAX) : 48'(m);
      end
      r.d_corr = (dk > gkrd_pkg::DK_MAX) ? 46'(gkrd_pkg::DK_MAX) : 46'(dk);
    end
    kernel_q.push_back(r);
  endfunction

  // Results are checked at the edge at which they are accepted.
  always @(posedge clk) begin
    gkrd_pkg::result_t want;
    if (rst_n && pop && !empty) begin
      if (kernel_q.size() == 0) begin
        $display("%0t: result with none expected: dist %h", $time, out_sq_distance);
        errors++;
      end else begin
        want = kernel_q.pop_front();
        if (out_sq_distance !== want.sq_distance) begin
          $display("%0t: sq_distance expected %h actual %h", $time, want.sq_distance,
                   out_sq_distance);
          errors++;
        end
        if (out_corr !== want.corr) begin
          $display("%0t: corr expected %h actual %h", $time, want.corr, out_corr);
          errors++;
        end
        if (out_d_corr !== want.d_corr) begin
          $display("%0t: d_corr expected %h actual %h", $time, want.d_corr, out_d_corr);
          errors++;
        end
        if (out_d2_corr !== want.d2_corr) begin
          $display("%0t: d2_corr expected %h actual %h", $time, want.d2_corr,
                   out_d2_corr);
          errors++;
        end
        if (out_matrix_done !== want.matrix_done) begin
          $display("%0t: matrix_done expected %b actual %b", $time, want.matrix_done,
                   out_matrix_done);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (idle_on) pop <= ($urandom_range(99) >= 35);
    else pop <= 1'b1;
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || !rst_n) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      gkrd_pkg::CFG_INV_RANGE:    m_inv_range = val;
      gkrd_pkg::CFG_INV_RANGE_SQ: m_inv_range_sq = val;
      gkrd_pkg::CFG_TWICE_RANGE:  m_twice_range = val;
      gkrd_pkg::CFG_NUGGET:       m_nugget = val[15:0];
      gkrd_pkg::CFG_ZERO_DIST:    m_zero_dist = val[0];
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [31:0] ir, logic [31:0] irsq, logic [31:0] tw,
                          logic [15:0] g, logic z);
    write_reg(gkrd_pkg::CFG_INV_RANGE, ir);
    write_reg(gkrd_pkg::CFG_INV_RANGE_SQ, irsq);
    write_reg(gkrd_pkg::CFG_TWICE_RANGE, tw);
    write_reg(gkrd_pkg::CFG_NUGGET, {16'b0, g});
    write_reg(gkrd_pkg::CFG_ZERO_DIST, {31'b0, z});
  endtask

  // Called and left at a falling edge; push drops only in random idle gaps.
  task automatic send_item(logic action, logic signed [23:0] ca, logic signed [23:0] cb,
                           logic [51:0] dist_in, logic last, logic diag, logic eom);
    if (idle_on && $urandom_range(99) < 35) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 2)) @(negedge clk);
    end
    push <= 1'b1;
    in_action <= action;
    in_coord_a <= ca;
    in_coord_b <= cb;
    in_distance_in <= dist_in;
    in_last_coord <= last;
    in_diagonal <= diag;
    in_end_of_matrix <= eom;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_kernel(action, ca, cb, dist_in, last, diag, eom);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (kernel_q.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  function automatic logic signed [23:0] rand_coord();
    case ($urandom_range(3))
      0: return 24'($urandom);
      1, 2: return 24'($signed($urandom_range(0, 131071)) - 65536);
      default: return $urandom_range(1) ? 24'sh7FFFFF : -24'sh800000;
    endcase
  endfunction

  function automatic logic [51:0] rand_dist();
    if ($urandom_range(3) == 0) return {20'($urandom), 32'($urandom)};
    return 52'($urandom) << $urandom_range(0, 4);
  endfunction

  function automatic logic [31:0] rand_reg();
    case ($urandom_range(4))
      0: return $urandom;
      1: return 0;
      default: return $urandom_range(32'h1000, 32'h80000);
    endcase
  endfunction

  task automatic send_pair();
    int dims;
    logic last;
    dims = $urandom_range(1, 4);
    for (int i = 0; i < dims; i++) begin
      last = (i == dims - 1);
      send_item($urandom_range(9) == 0, rand_coord(), rand_coord(), rand_dist(), last,
                last && ($urandom_range(7) == 0), last && $urandom_range(1));
    end
  endtask

  task automatic test_directed_pairs();
    send_item(1'b0, 24'sh7FFFFF, -24'sh800000, 52'd0, 1'b1, 1'b0, 1'b1);
    send_item(1'b0, -24'sh800000, 24'sh7FFFFF, 52'd0, 1'b1, 1'b0, 1'b0);
    send_item(1'b0, 24'sh010000, 24'sh000000, 52'd0, 1'b0, 1'b0, 1'b0);
    send_item(1'b0, 24'sh000000, 24'sh008000, 52'd0, 1'b1, 1'b0, 1'b1);
    for (int i = 0; i < 17; i++)
      send_item(1'b0, 24'sh7FFFFF, -24'sh800000, 52'd0, i == 16, 1'b0, 1'b0);
    send_item(1'b0, 24'sh030000, 24'sh000000, 52'd0, 1'b0, 1'b0, 1'b0);
    send_item(1'b1, 24'sh0, 24'sh0, 52'h0_8000_0000, 1'b0, 1'b0, 1'b0);
    send_item(1'b0, 24'sh008000, 24'sh000000, 52'd0, 1'b1, 1'b0, 1'b1);
    send_item(1'b1, 24'sh0, 24'sh0, gkrd_pkg::ACC_MAX, 1'b1, 1'b0, 1'b0);
    send_item(1'b1, 24'sh0, 24'sh0, 52'h20_0000_0000, 1'b1, 1'b0, 1'b0);
    send_item(1'b1, 24'sh0, 24'sh0, 52'h2_0000_0000, 1'b1, 1'b1, 1'b1);
    send_item(1'b0, 24'sh123456, 24'sh123456, 52'd0, 1'b1, 1'b0, 1'b0);
    send_item(1'b1, 24'sh0, 24'sh0, 52'd0, 1'b1, 1'b0, 1'b1);
    wait_drained();
  endtask

  task automatic test_register_extremes();
    set_regs(32'h10000, 32'h10000, 32'h20000, 16'hFFFF, 1'b1);
    test_directed_pairs();
    set_regs(32'h0, 32'h0, 32'h0, 16'h0, 1'b0);
    test_directed_pairs();
    set_regs(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 1'b1);
    test_directed_pairs();
    set_regs(32'h8000, 32'hFFFFFFFF, 32'h40000, 16'h1234, 1'b0);
    for (int i = 0; i < 20; i++)
      send_item(1'b1, 24'sh0, 24'sh0, 52'h1_0000_0000 * i, 1'b1, 1'b0, 1'b0);
    wait_drained();
  endtask

  task automatic test_random_pairs(int n_pairs);
    for (int i = 0; i < n_pairs; i++) begin
      send_pair();
      if (i == n_pairs / 2) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = gkrd_pkg::CFG_INV_RANGE;
    cfg_wdata = 0;
    push = 1'b0;
    in_action = 1'b0;
    in_coord_a = 0;
    in_coord_b = 0;
    in_distance_in = 0;
    in_last_coord = 1'b0;
    in_diagonal = 1'b0;
    in_end_of_matrix = 1'b0;
    errors = 0;
    idle_on = 1'b1;
    build_exp_tables();
    m_inv_range = 32'h10000;
    m_inv_range_sq = 32'h10000;
    m_twice_range = 32'h20000;
    m_nugget = 0;
    m_zero_dist = 1'b0;
    m_dist_sum = 0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed_pairs();
    test_register_extremes();
    idle_on = 1'b0;
    test_random_pairs(80);
    idle_on = 1'b1;
    for (int ph = 0; ph < 5; ph++) begin
      set_regs(rand_reg(), rand_reg(), rand_reg(), 16'($urandom), 1'($urandom));
      test_random_pairs(100);
    end

    if (errors == 0 && kernel_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/gkrd_pkg.sv
design/gkrd_fifo.sv
design/gkrd_front.sv
design/gkrd_mul.sv
design/gkrd_back.sv
design/gaussian_kernel_with_range_derivs_core.sv
dv/tb_gaussian_kernel_with_range_derivs_core.sv
